### hw/rtl/hxf_pkg.sv
// Shared types, constants and the arctangent table for the 2D transform pipeline.
package hxf_pkg;

    localparam int XY_W = 34;   // CORDIC x/y datapath, Q2.30 plus headroom
    localparam int Z_W  = 26;   // CORDIC residual angle, degrees with 16 fraction bits
    localparam int CS_W = 26;   // rounded sine/cosine, Q2.22
    localparam int SX_W = 41;   // scaled offset, Q16.16 at full width

    localparam int DEG360 = 92160;
    localparam int DEG180 = 46080;
    localparam int DEG90  = 23040;
    localparam logic signed [XY_W-1:0] CORDIC_K = XY_W'(652032874);

    typedef struct packed {
        logic                   is_root;
        logic                   rot;
        logic                   neg;
        logic                   sat;
        logic signed [31:0]     lx;
        logic signed [31:0]     ly;
        logic signed [31:0]     px;
        logic signed [31:0]     py;
        logic [23:0]            ls;
        logic signed [19:0]     la;
        logic [23:0]            scale;
        logic signed [19:0]     angle;
        logic signed [SX_W-1:0] sx;
        logic signed [SX_W-1:0] sy;
    } side_t;

    // atan(2^-i) in degrees with 16 fraction bits.
    function automatic logic [Z_W-1:0] atan_deg(input int unsigned idx);
        logic [Z_W-1:0] r;
        case (idx)
            0:       r = Z_W'(2949120);
            1:       r = Z_W'(1740967);
            2:       r = Z_W'(919879);
            3:       r = Z_W'(466945);
            4:       r = Z_W'(234379);
            5:       r = Z_W'(117304);
            6:       r = Z_W'(58666);
            7:       r = Z_W'(29335);
            8:       r = Z_W'(14668);
            9:       r = Z_W'(7334);
            10:      r = Z_W'(3667);
            11:      r = Z_W'(1833);
            12:      r = Z_W'(917);
            13:      r = Z_W'(458);
            14:      r = Z_W'(229);
            15:      r = Z_W'(115);
            16:      r = Z_W'(57);
            17:      r = Z_W'(29);
            18:      r = Z_W'(14);
            19:      r = Z_W'(7);
            20:      r = Z_W'(4);
            21:      r = Z_W'(2);
            22:      r = Z_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/hxf_front.sv
// Front stages: offset and scale products, angle sum, rotation gate and quadrant folding.
module hxf_front
    import hxf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  is_root,
    input  logic signed [31:0]    local_x,
    input  logic signed [31:0]    local_y,
    input  logic [23:0]           local_scale,
    input  logic signed [19:0]    local_angle,
    input  logic signed [31:0]    parent_x,
    input  logic signed [31:0]    parent_y,
    input  logic [23:0]           parent_scale,
    input  logic signed [19:0]    parent_angle,
    input  logic [15:0]           min_rotation,
    output logic                  out_valid,
    input  logic                  out_ready,
    output side_t                 out_side,
    output logic signed [Z_W-1:0] out_z
);

    logic adv0, adv1;
    logic v0_reg, v1_reg;

    // Stage 0 registers.
    logic               root0_reg, rot0_reg, neg0_reg;
    logic signed [31:0] lx0_reg, ly0_reg, px0_reg, py0_reg;
    logic [23:0]        ls0_reg;
    logic signed [19:0] la0_reg;
    logic signed [56:0] pxl0_reg, pyl0_reg;
    logic [47:0]        pls0_reg;
    logic signed [20:0] asum0_reg;
    logic signed [20:0] t0_reg;

    // Stage 1 registers.
    side_t                 side1_reg;
    logic signed [Z_W-1:0] z1_reg;

    logic signed [20:0] t_a, t_b, t_next, mag;
    logic               neg_next, rot_next;

    assign adv1     = !v1_reg || out_ready;
    assign adv0     = !v0_reg || adv1;
    assign in_ready = adv0;

    always_comb
    begin
        mag = parent_angle[19] ? -{parent_angle[19], parent_angle}
                               : {parent_angle[19], parent_angle};
        rot_next = (int'(mag) > int'(min_rotation)) &&
                   (int'(mag) < DEG360 - int'(min_rotation));
        t_a = -{parent_angle[19], parent_angle};
        if (int'(t_a) > DEG180)
        begin
            t_b = 21'(int'(t_a) - DEG360);
        end
        else if (int'(t_a) < -DEG180)
        begin
            t_b = 21'(int'(t_a) + DEG360);
        end
        else
        begin
            t_b = t_a;
        end
        // Fold into the right half plane; both sine and cosine flip sign.
        neg_next = 1'b0;
        t_next   = t_b;
        if (int'(t_b) > DEG90)
        begin
            t_next   = 21'(int'(t_b) - DEG180);
            neg_next = 1'b1;
        end
        else if (int'(t_b) < -DEG90)
        begin
            t_next   = 21'(int'(t_b) + DEG180);
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                v0_reg <= in_valid;
            end
            if (adv1)
            begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            root0_reg <= is_root;
            rot0_reg  <= rot_next;
            neg0_reg  <= neg_next;
            lx0_reg   <= local_x;
            ly0_reg   <= local_y;
            px0_reg   <= parent_x;
            py0_reg   <= parent_y;
            ls0_reg   <= local_scale;
            la0_reg   <= local_angle;
            pxl0_reg  <= $signed({1'b0, parent_scale}) * local_x;
            pyl0_reg  <= $signed({1'b0, parent_scale}) * local_y;
            pls0_reg  <= parent_scale * local_scale;
            asum0_reg <= {parent_angle[19], parent_angle} + {local_angle[19], local_angle};
            t0_reg    <= t_next;
        end
    end

    logic signed [57:0] sxs, sys;
    logic [48:0]        scs;
    logic [32:0]        scq;
    side_t              side_next;

    always_comb
    begin
        sxs = {pxl0_reg[56], pxl0_reg} + 58'sd32768;
        sys = {pyl0_reg[56], pyl0_reg} + 58'sd32768;
        scs = {1'b0, pls0_reg} + 49'd32768;
        scq = scs[48:16];

        side_next.is_root = root0_reg;
        side_next.rot     = rot0_reg;
        side_next.neg     = neg0_reg;
        side_next.lx      = lx0_reg;
        side_next.ly      = ly0_reg;
        side_next.px      = px0_reg;
        side_next.py      = py0_reg;
        side_next.ls      = ls0_reg;
        side_next.la      = la0_reg;
        side_next.sx      = sxs[56:16];
        side_next.sy      = sys[56:16];
        side_next.sat     = 1'b0;
        if (scq > 33'h0FFFFFF)
        begin
            side_next.scale = 24'hFFFFFF;
            side_next.sat   = 1'b1;
        end
        else
        begin
            side_next.scale = scq[23:0];
        end
        if (asum0_reg > 21'sd524287)
        begin
            side_next.angle = 20'sd524287;
            side_next.sat   = 1'b1;
        end
        else if (asum0_reg < -21'sd524288)
        begin
            side_next.angle = -20'sd524288;
            side_next.sat   = 1'b1;
        end
        else
        begin
            side_next.angle = asum0_reg[19:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            side1_reg <= side_next;
            z1_reg    <= {t0_reg[Z_W-9:0], 8'h00};
        end
    end

    assign out_valid = v1_reg;
    assign out_side  = side1_reg;
    assign out_z     = z1_reg;

endmodule

### hw/rtl/hxf_cordic.sv
// Pipelined CORDIC in rotation mode, one micro-rotation per register stage.
module hxf_cordic
    import hxf_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  side_t                  in_side,
    input  logic signed [Z_W-1:0]  in_z,
    output logic                   out_valid,
    input  logic                   out_ready,
    output side_t                  out_side,
    output logic signed [XY_W-1:0] out_x,
    output logic signed [XY_W-1:0] out_y
);

    logic [STAGES-1:0]     v_reg;
    logic [STAGES:0]       adv;
    logic signed [XY_W-1:0] x_reg [STAGES];
    logic signed [XY_W-1:0] y_reg [STAGES];
    logic signed [Z_W-1:0]  z_reg [STAGES];
    side_t                  side_reg [STAGES];

    assign adv[STAGES] = out_ready;
    assign in_ready    = adv[0];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic                   v_in;
        logic signed [XY_W-1:0] x_in, y_in, dx, dy;
        logic signed [Z_W-1:0]  z_in;
        side_t                  s_in;

        if (i == 0)
        begin : g_first
            assign v_in = in_valid;
            assign x_in = CORDIC_K;
            assign y_in = '0;
            assign z_in = in_z;
            assign s_in = in_side;
        end
        else
        begin : g_next
            assign v_in = v_reg[i-1];
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign s_in = side_reg[i-1];
        end

        assign adv[i] = !v_reg[i] || adv[i+1];
        assign dx     = y_in >>> i;
        assign dy     = x_in >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (adv[i])
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[i])
            begin
                side_reg[i] <= s_in;
                if (!z_in[Z_W-1])
                begin
                    x_reg[i] <= x_in - dx;
                    y_reg[i] <= y_in + dy;
                    z_reg[i] <= z_in - $signed(atan_deg(i));
                end
                else
                begin
                    x_reg[i] <= x_in + dx;
                    y_reg[i] <= y_in - dy;
                    z_reg[i] <= z_in + $signed(atan_deg(i));
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];
    assign out_x     = x_reg[STAGES-1];
    assign out_y     = y_reg[STAGES-1];

endmodule

### hw/rtl/hxf_rotate.sv
// Back stages: sine/cosine rounding, split rotation products, position add and saturation.
module hxf_rotate
    import hxf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  side_t                  in_side,
    input  logic signed [XY_W-1:0] in_x,
    input  logic signed [XY_W-1:0] in_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [31:0]     abs_x,
    output logic signed [31:0]     abs_y,
    output logic [23:0]            abs_scale,
    output logic signed [19:0]     abs_angle,
    output logic                   saturated
);

    localparam int P_W = 67;
    localparam int R_W = 46;

    logic [4:0] v_reg;
    logic [4:0] adv;

    assign adv[4]   = !v_reg[4] || out_ready;
    assign adv[3]   = !v_reg[3] || adv[4];
    assign adv[2]   = !v_reg[2] || adv[3];
    assign adv[1]   = !v_reg[1] || adv[2];
    assign adv[0]   = !v_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0]) v_reg[0] <= in_valid;
            if (adv[1]) v_reg[1] <= v_reg[0];
            if (adv[2]) v_reg[2] <= v_reg[1];
            if (adv[3]) v_reg[3] <= v_reg[2];
            if (adv[4]) v_reg[4] <= v_reg[3];
        end
    end

    // Stage 0: round to Q2.22, undo the half-turn fold, bypass when rotation is skipped.
    side_t                  side0_reg;
    logic signed [CS_W-1:0] cs0_reg, sn0_reg;
    logic signed [XY_W:0]   xs, ys;
    logic signed [CS_W-1:0] xr, yr, cs_next, sn_next;

    always_comb
    begin
        xs = {in_x[XY_W-1], in_x} + (XY_W+1)'(128);
        ys = {in_y[XY_W-1], in_y} + (XY_W+1)'(128);
        xr = xs[CS_W+7:8];
        yr = ys[CS_W+7:8];
        if (!in_side.rot)
        begin
            cs_next = CS_W'(1 << 22);
            sn_next = '0;
        end
        else if (in_side.neg)
        begin
            cs_next = -xr;
            sn_next = -yr;
        end
        else
        begin
            cs_next = xr;
            sn_next = yr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            side0_reg <= in_side;
            cs0_reg   <= cs_next;
            sn0_reg   <= sn_next;
        end
    end

    // Stage 1: each 41 x 26 product is split into a low unsigned and a high signed part.
    side_t              side1_reg;
    logic signed [50:0] xc_lo_reg, ys_lo_reg, yc_lo_reg, xs_lo_reg;
    logic signed [42:0] xc_hi_reg, ys_hi_reg, yc_hi_reg, xs_hi_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            side1_reg <= side0_reg;
            xc_lo_reg <= $signed({1'b0, side0_reg.sx[23:0]}) * cs0_reg;
            ys_lo_reg <= $signed({1'b0, side0_reg.sy[23:0]}) * sn0_reg;
            yc_lo_reg <= $signed({1'b0, side0_reg.sy[23:0]}) * cs0_reg;
            xs_lo_reg <= $signed({1'b0, side0_reg.sx[23:0]}) * sn0_reg;
            xc_hi_reg <= $signed(side0_reg.sx[SX_W-1:24]) * cs0_reg;
            ys_hi_reg <= $signed(side0_reg.sy[SX_W-1:24]) * sn0_reg;
            yc_hi_reg <= $signed(side0_reg.sy[SX_W-1:24]) * cs0_reg;
            xs_hi_reg <= $signed(side0_reg.sx[SX_W-1:24]) * sn0_reg;
        end
    end

    // Stage 2: recombine the partial products.
    side_t                 side2_reg;
    logic signed [P_W-1:0] pxc_reg, pys_reg, pyc_reg, pxs_reg;

    function automatic logic signed [P_W-1:0] join_pp(input logic signed [42:0] hi,
                                                      input logic signed [50:0] lo);
        logic signed [P_W-1:0] h, l;
        h = {hi, 24'h0};
        l = {{(P_W-51){lo[50]}}, lo};
        return h + l;
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            side2_reg <= side1_reg;
            pxc_reg   <= join_pp(xc_hi_reg, xc_lo_reg);
            pys_reg   <= join_pp(ys_hi_reg, ys_lo_reg);
            pyc_reg   <= join_pp(yc_hi_reg, yc_lo_reg);
            pxs_reg   <= join_pp(xs_hi_reg, xs_lo_reg);
        end
    end

    // Stage 3: rotated offset, rounded half up back to Q16.16.
    side_t                 side3_reg;
    logic signed [R_W-1:0] rx3_reg, ry3_reg;
    logic signed [P_W:0]   dxs, dys;

    always_comb
    begin
        dxs = {pxc_reg[P_W-1], pxc_reg} - {pys_reg[P_W-1], pys_reg} + (P_W+1)'(1 << 21);
        dys = {pyc_reg[P_W-1], pyc_reg} + {pxs_reg[P_W-1], pxs_reg} + (P_W+1)'(1 << 21);
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            side3_reg <= side2_reg;
            rx3_reg   <= dxs[P_W:22];
            ry3_reg   <= dys[P_W:22];
        end
    end

    // Stage 4: add the parent position and saturate.
    logic signed [R_W:0] ax_sum, ay_sum;
    logic signed [31:0]  ax_next, ay_next;
    logic                xsat, ysat;

    always_comb
    begin
        ax_sum = {{(R_W-31){side3_reg.px[31]}}, side3_reg.px} + {rx3_reg[R_W-1], rx3_reg};
        ay_sum = {{(R_W-31){side3_reg.py[31]}}, side3_reg.py} + {ry3_reg[R_W-1], ry3_reg};
        xsat   = 1'b1;
        ysat   = 1'b1;
        if (ax_sum > (R_W+1)'(32'sh7FFFFFFF))
        begin
            ax_next = 32'sh7FFFFFFF;
        end
        else if (ax_sum < -(R_W+1)'(33'sh080000000))
        begin
            ax_next = 32'sh80000000;
        end
        else
        begin
            ax_next = ax_sum[31:0];
            xsat    = 1'b0;
        end
        if (ay_sum > (R_W+1)'(32'sh7FFFFFFF))
        begin
            ay_next = 32'sh7FFFFFFF;
        end
        else if (ay_sum < -(R_W+1)'(33'sh080000000))
        begin
            ay_next = 32'sh80000000;
        end
        else
        begin
            ay_next = ay_sum[31:0];
            ysat    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            if (side3_reg.is_root)
            begin
                abs_x     <= side3_reg.lx;
                abs_y     <= side3_reg.ly;
                abs_scale <= side3_reg.ls;
                abs_angle <= side3_reg.la;
                saturated <= 1'b0;
            end
            else
            begin
                abs_x     <= ax_next;
                abs_y     <= ay_next;
                abs_scale <= side3_reg.scale;
                abs_angle <= side3_reg.angle;
                saturated <= side3_reg.sat || xsat || ysat;
            end
        end
    end

    assign out_valid = v_reg[4];

endmodule

### hw/rtl/hierarchical_2d_transform.sv
// Top level of the 2D transform composition pipeline.
//
// One node per word on the s_axis side: the child's local position, scale
// and angle and the parent's absolute ones, with tuser marking a root node.
// Each accepted word gives exactly one word on the m_axis side carrying the
// absolute position, scale and angle, with tuser set when any result clipped.
// The cfg channel writes the rotation threshold (Q8.8 degrees); it is
// always ready and should be written while the pipeline is empty.
// There are two front stages, one stage per CORDIC micro-rotation and
// five stages for the rotation products and the final add. A new word can
// enter every cycle unless m_tready stalls it. Every stage has its own valid
// bit and advances when its successor has room, so a stalled receiver fills
// the bubbles first and then holds s_tready low; nothing is dropped or
// repeated. Reset empties the pipeline and sets the threshold to 0.5 degree.
module hierarchical_2d_transform
    import hxf_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // local_x, local_y, local_scale, local_angle, parent_x, parent_y,
    // parent_scale, parent_angle
    input  logic [215:0] s_tdata,
    // is_root
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // abs_x, abs_y, abs_scale, abs_angle, four zero bits
    output logic [111:0] m_tdata,
    // saturated
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    logic [15:0] min_rotation_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rotation_reg <= 16'd128;
        end
        else if (cfg_valid)
        begin
            min_rotation_reg <= cfg_data;
        end
    end

    logic                   f_valid, f_ready;
    side_t                  f_side;
    logic signed [Z_W-1:0]  f_z;
    logic                   c_valid, c_ready;
    side_t                  c_side;
    logic signed [XY_W-1:0] c_x, c_y;
    logic signed [31:0]     abs_x, abs_y;
    logic [23:0]            abs_scale;
    logic signed [19:0]     abs_angle;
    logic                   saturated;

    hxf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .is_root      (s_tuser[0]),
        .local_x      ($signed(s_tdata[31:0])),
        .local_y      ($signed(s_tdata[63:32])),
        .local_scale  (s_tdata[87:64]),
        .local_angle  ($signed(s_tdata[107:88])),
        .parent_x     ($signed(s_tdata[139:108])),
        .parent_y     ($signed(s_tdata[171:140])),
        .parent_scale (s_tdata[195:172]),
        .parent_angle ($signed(s_tdata[215:196])),
        .min_rotation (min_rotation_reg),
        .out_valid    (f_valid),
        .out_ready    (f_ready),
        .out_side     (f_side),
        .out_z        (f_z)
    );

    hxf_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_side   (f_side),
        .in_z      (f_z),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_side  (c_side),
        .out_x     (c_x),
        .out_y     (c_y)
    );

    hxf_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .in_side   (c_side),
        .in_x      (c_x),
        .in_y      (c_y),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .abs_x     (abs_x),
        .abs_y     (abs_y),
        .abs_scale (abs_scale),
        .abs_angle (abs_angle),
        .saturated (saturated)
    );

    assign m_tdata = {4'h0, abs_angle, abs_scale, abs_y, abs_x};
    assign m_tuser = saturated;

endmodule
